// ===== hw/rtl/rble_pkg.sv =====
// Shared types, sizes and pointer helpers for the ring byte buffer with line extraction.
// Used by the RAM-facing top level; no dependencies of its own.
`default_nettype none

package rble_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int DATA_W = 8;
    localparam int ACT_W  = 2;
    localparam int SKIP_W = 6;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 6;

    // The ring holds at most DEPTH-1 bytes so that equal pointers always mean empty.
    localparam logic [PTR_W-1:0] CNT_MAX = PTR_W'(DEPTH - 1);

    localparam logic [DATA_W-1:0] MARK_RESET = 8'd10;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_MARK = 2'd1,
        ACT_ALL  = 2'd2,
        ACT_SKIP = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DATA      = 3'd0,
        ST_PUSH_OK   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_SKIP      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    // Ring address p advanced by n, where both are below DEPTH.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (PTR_W+1)'(DEPTH)) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return ptr_add(p, PTR_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rble_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; sized by its WIDTH and DEPTH parameters.
`default_nettype none

module rble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/ring_byte_buffer_line_extract_top.sv =====
// Top level of the ring byte buffer: request sequencer, pointers and result registers.
// Depends on rble_pkg and instantiates rble_ram for the byte ring.
// Push, skip and any request on an empty ring answer in the cycle after acceptance and keep
// busy low, so such requests can be issued every cycle.
// Consume-to-mark compares one stored byte per cycle through the single RAM read port; once
// the mark is found the bytes up to it are read again from the read pointer and emitted, and
// with no mark among the stored bytes a not-found answer is given.
// Consume-all reads the whole ring from the read pointer; every run emits one byte
// per cycle. Synchronous active-low reset empties the ring and sets the mark byte to newline.
`default_nettype none

module ring_byte_buffer_line_extract_top
    import rble_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [DATA_W-1:0] i_byte_in,
    input  wire logic [SKIP_W-1:0] i_skip_count,
    output logic                   o_valid,
    output logic      [DATA_W-1:0] o_data_byte,
    output logic                   o_last,
    output logic      [STAT_W-1:0] o_status,
    output logic      [LEN_W-1:0]  o_run_length,
    output logic      [LEN_W-1:0]  o_available,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_addr, n_addr;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic [PTR_W-1:0]  r_pos, n_pos;
    logic [PTR_W-1:0]  r_run, n_run;
    logic [PTR_W-1:0]  r_after, n_after;
    logic              r_rd_vld, n_rd_vld;
    logic [DATA_W-1:0] r_mark, n_mark;

    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_avail, n_avail;

    logic              accept;
    t_action           act;
    logic              full;
    logic [PTR_W-1:0]  skip_n;
    logic              found;
    logic [PTR_W-1:0]  found_run;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_q;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign act         = t_action'(i_action);
    assign full        = (r_count == CNT_MAX);
    assign skip_n      = (i_skip_count < LEN_W'(r_count)) ? PTR_W'(i_skip_count) : r_count;
    assign found       = r_rd_vld && (ram_q == r_mark);
    assign found_run   = r_pos + PTR_W'(1);

    rble_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_byte_in),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (r_count != '0)) begin
                    if (act == ACT_MARK) begin
                        n_state = S_SCAN;
                    end else if (act == ACT_ALL) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_state = S_EMIT;
                end else if ((r_idx == r_count) && !r_rd_vld) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (r_rd_vld && (r_pos == r_run - PTR_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control and result generation.
    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_count  = r_count;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_run    = r_run;
        n_after  = r_after;
        n_rd_vld = 1'b0;
        n_mark   = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_mark;
        n_valid  = 1'b0;
        n_data   = '0;
        n_last   = 1'b1;
        n_status = ST_DATA;
        n_len    = '0;
        n_avail  = LEN_W'(r_count);
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (act)
                        ACT_PUSH: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                ram_we   = 1'b1;
                                n_wp     = ptr_inc(r_wp);
                                n_count  = r_count + PTR_W'(1);
                                n_status = ST_PUSH_OK;
                                n_avail  = LEN_W'(r_count + PTR_W'(1));
                            end
                        end
                        ACT_MARK: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_addr = r_rp;
                                n_idx  = '0;
                                n_pos  = '0;
                            end
                        end
                        ACT_ALL: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_addr  = r_rp;
                                n_idx   = '0;
                                n_pos   = '0;
                                n_run   = r_count;
                                n_after = '0;
                                n_rp    = r_wp;
                                n_count = '0;
                            end
                        end
                        ACT_SKIP: begin
                            n_rp     = ptr_add(r_rp, skip_n);
                            n_count  = r_count - skip_n;
                            n_valid  = 1'b1;
                            n_status = ST_SKIP;
                            n_len    = LEN_W'(skip_n);
                            n_avail  = LEN_W'(r_count - skip_n);
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // One read in flight: r_pos tracks the ring offset of the byte in ram_q.
                if (found) begin
                    n_run   = found_run;
                    n_after = r_count - found_run;
                    n_rp    = ptr_add(r_rp, found_run);
                    n_count = r_count - found_run;
                    n_addr  = r_rp;
                    n_idx   = '0;
                    n_pos   = '0;
                end else if (r_idx != r_count) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_addr   = ptr_inc(r_addr);
                    n_idx    = r_idx + PTR_W'(1);
                    n_pos    = r_idx;
                end else if (!r_rd_vld) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                end
            end
            S_EMIT: begin
                if (r_idx != r_run) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_addr   = ptr_inc(r_addr);
                    n_idx    = r_idx + PTR_W'(1);
                end
                if (r_rd_vld) begin
                    n_valid  = 1'b1;
                    n_data   = ram_q;
                    n_status = ST_DATA;
                    n_last   = (r_pos == r_run - PTR_W'(1));
                    n_len    = LEN_W'(r_run);
                    n_avail  = LEN_W'(r_after);
                    n_pos    = r_pos + PTR_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_mark   <= MARK_RESET;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_mark   <= n_mark;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_after  <= n_after;
        r_data   <= n_data;
        r_last   <= n_last;
        r_status <= n_status;
        r_len    <= n_len;
        r_avail  <= n_avail;
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_data;
    assign o_last       = r_last;
    assign o_status     = r_status;
    assign o_run_length = r_len;
    assign o_available  = r_avail;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("ring holds more bytes than it can");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> !busy)
        else $error("final result shown while still busy");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_DATA) |-> r_last)
        else $error("status result not marked last");

    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (act == ACT_PUSH) && !full |=> r_valid && (r_status == ST_PUSH_OK)
            && (r_count == $past(r_count) + PTR_W'(1)))
        else $error("push transaction not answered");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx <= r_run) && (r_pos < r_run))
        else $error("emit index beyond run length");
`endif

endmodule

`default_nettype wire
